// ----- hw/rtl/wtosc_pkg.sv -----
// ----------------------------------------------------------------------------
// Wavetable oscillator package
// Shared types and constants for the bilinear wavetable oscillator.
// ----------------------------------------------------------------------------
package wtosc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int PHASE_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TRIG  = 2'd2
    } wtosc_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC  = 3'd0,
        CFG_SCAN_INC   = 3'd1,
        CFG_FRAME_POS  = 3'd2,
        CFG_GAIN_LEFT  = 3'd3,
        CFG_GAIN_RIGHT = 3'd4,
        CFG_PHASE_MODE = 3'd5,
        CFG_SCAN_MODE  = 3'd6,
        CFG_FIXED_PH   = 3'd7
    } wtosc_cfg_idx_t;

    typedef enum logic [1:0] {
        PM_ZERO   = 2'd0,
        PM_FIXED  = 2'd1,
        PM_RANDOM = 2'd2
    } wtosc_pmode_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic       tbl_write;
        logic       trig;
        logic       scan_step;
        logic       frame_load;
        logic       frame_wrap;
        logic       base_load;
        logic       pos_load;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       cap_en;
        logic [1:0] cap_sel;
        logic       row_load;
        logic       col_load;
        logic       acc_clr;
        logic       acc_add;
        logic       gain_load;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } wtosc_cmd_t;

    typedef struct packed {
        logic out_busy;
    } wtosc_status_t;

endpackage

// ----- hw/rtl/wtosc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module wtosc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hw/rtl/wtosc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Wavetable oscillator sequencer
// Accepts input transactions and steps the datapath through one tick.
// ----------------------------------------------------------------------------
module wtosc_ctrl #(
    parameter int OVERSAMPLE_FACTOR = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [1:0]               opcode,
    input  wtosc_pkg::wtosc_status_t status,
    output wtosc_pkg::wtosc_cmd_t    cmd
);
    import wtosc_pkg::*;

    localparam int PC_W = (OVERSAMPLE_FACTOR > 1) ? $clog2(OVERSAMPLE_FACTOR) : 1;
    localparam logic [PC_W-1:0] PASS_LAST = PC_W'(OVERSAMPLE_FACTOR - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_FRAME, ST_WRAP, ST_BASE, ST_POS, ST_RD, ST_RDLAST,
        ST_ROW, ST_COL, ST_ACC, ST_GAIN, ST_DINIT, ST_DIV, ST_OUT
    } state_t;

    state_t          state_reg;
    logic [1:0]      rd_cnt_reg;
    logic [PC_W-1:0] pass_cnt_reg;

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_cnt_reg   <= '0;
            pass_cnt_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid && opcode == OP_TICK)
                    begin
                        pass_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN:  state_reg <= ST_FRAME;
                ST_FRAME: state_reg <= ST_WRAP;
                ST_WRAP:  state_reg <= ST_BASE;
                ST_BASE:  state_reg <= ST_POS;
                ST_POS:
                begin
                    rd_cnt_reg <= '0;
                    state_reg  <= ST_RD;
                end
                ST_RD:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 2'd1;
                    if (rd_cnt_reg == 2'd3)
                    begin
                        state_reg <= ST_RDLAST;
                    end
                end
                ST_RDLAST: state_reg <= ST_ROW;
                ST_ROW:    state_reg <= ST_COL;
                ST_COL:    state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (pass_cnt_reg == PASS_LAST)
                    begin
                        state_reg <= ST_GAIN;
                    end
                    else
                    begin
                        pass_cnt_reg <= pass_cnt_reg + PC_W'(1);
                        state_reg    <= ST_POS;
                    end
                end
                ST_GAIN:  state_reg <= ST_DINIT;
                ST_DINIT: state_reg <= ST_DIV;
                ST_DIV:   state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (!status.out_busy)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.tbl_write = s_tvalid && (opcode == OP_WRITE);
                cmd.trig      = s_tvalid && (opcode == OP_TRIG);
                cmd.acc_clr   = s_tvalid && (opcode == OP_TICK);
            end
            ST_SCAN:  cmd.scan_step  = 1'b1;
            ST_FRAME: cmd.frame_load = 1'b1;
            ST_WRAP:  cmd.frame_wrap = 1'b1;
            ST_BASE:  cmd.base_load  = 1'b1;
            ST_POS:   cmd.pos_load   = 1'b1;
            ST_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = rd_cnt_reg;
                cmd.cap_en  = (rd_cnt_reg != 2'd0);
                cmd.cap_sel = rd_cnt_reg - 2'd1;
            end
            ST_RDLAST:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = 2'd3;
            end
            ST_ROW:   cmd.row_load  = 1'b1;
            ST_COL:   cmd.col_load  = 1'b1;
            ST_ACC:   cmd.acc_add   = 1'b1;
            ST_GAIN:  cmd.gain_load = 1'b1;
            ST_DINIT: cmd.div_init  = 1'b1;
            ST_DIV:   cmd.div_step  = 1'b1;
            ST_OUT:   cmd.out_load  = !status.out_busy;
            default:  cmd = '0;
        endcase
    end

endmodule

// ----- hw/rtl/wtosc_dp.sv -----
// ----------------------------------------------------------------------------
// Wavetable oscillator datapath
// Configuration, phases, table, bilinear interpolation, gain and divide.
// ----------------------------------------------------------------------------
module wtosc_dp #(
    parameter int NUM_FRAMES_P      = 256,
    parameter int FRAME_LENGTH      = 2048,
    parameter int OVERSAMPLE_FACTOR = 4,
    parameter int SAMPLE_BITS       = 24,
    parameter int SUM_W             = 35
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wtosc_pkg::wtosc_cmd_t                cmd,
    output wtosc_pkg::wtosc_status_t             status,
    input  logic                                 cfg_we,
    input  logic [wtosc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wtosc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [18:0]                          table_address,
    input  logic signed [wtosc_pkg::SAMPLE_W-1:0] table_value,
    input  logic [31:0]                          random_phase,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic signed [wtosc_pkg::SAMPLE_W-1:0] left_sample,
    output logic signed [wtosc_pkg::SAMPLE_W-1:0] right_sample
);
    import wtosc_pkg::*;

    localparam int FL_W  = $clog2(FRAME_LENGTH);
    localparam int NF_W  = $clog2(NUM_FRAMES_P);
    localparam int IW    = (NF_W > 8) ? NF_W : 8;
    localparam int DEPTH = NUM_FRAMES_P * FRAME_LENGTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = (AW + 1 > 19) ? AW + 1 : 19;
    localparam int ROW_W = 42;
    localparam int COL_W = 60;
    localparam int PV_W  = 61;
    localparam int GP_W  = SUM_W + 17;
    localparam int T_W   = GP_W - 22;
    localparam int DIV_W = T_W;
    localparam int DL    = (OVERSAMPLE_FACTOR > 1) ? $clog2(OVERSAMPLE_FACTOR) : 0;
    localparam int RSH   = DIV_W + DL;
    localparam int MP_W  = 2 * DIV_W + 1;
    localparam int Q_W   = (DIV_W + 1 > SAMPLE_BITS + 1) ? DIV_W + 1 : SAMPLE_BITS + 1;

    localparam logic [NF_W-1:0]   NF_M1   = NF_W'(NUM_FRAMES_P - 1);
    localparam logic [NF_W:0]     NF_C    = (NF_W + 1)'(NUM_FRAMES_P);
    localparam logic [FL_W:0]     FL_C    = (FL_W + 1)'(FRAME_LENGTH);
    localparam logic [FL_W-1:0]   FL_M1   = FL_W'(FRAME_LENGTH - 1);
    localparam logic [AW-1:0]     FL_AW   = AW'(FRAME_LENGTH);
    localparam logic [CW-1:0]     DEPTH_C = CW'(DEPTH);
    localparam logic [DIV_W-1:0]  OS_M1   = DIV_W'(OVERSAMPLE_FACTOR - 1);
    // Reciprocal of the oversample factor, rounded up; for a DIV_W-bit dividend
    // the product shifted down by RSH is the exact floor quotient.
    localparam logic [DIV_W:0]    RECIP   = (DIV_W + 1)'(((64'd1 << RSH)
        + 64'(OVERSAMPLE_FACTOR) - 64'd1) / 64'(OVERSAMPLE_FACTOR));
    localparam logic signed [Q_W-1:0] SAT_HI = Q_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] SAT_LO = -SAT_HI - Q_W'(1);

    // Configuration registers
    logic [30:0] phase_inc_reg;
    logic [31:0] scan_inc_reg;
    logic [23:0] frame_pos_reg;
    logic [15:0] gain_reg [2];
    logic [1:0]  phase_mode_reg;
    logic        scan_mode_reg;
    logic [31:0] fixed_phase_reg;

    logic [31:0] osc_phase_reg;
    logic [31:0] scan_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg   <= '0;
            scan_inc_reg    <= '0;
            frame_pos_reg   <= '0;
            gain_reg[0]     <= 16'd16384;
            gain_reg[1]     <= 16'd16384;
            phase_mode_reg  <= '0;
            scan_mode_reg   <= 1'b0;
            fixed_phase_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PHASE_INC:  phase_inc_reg   <= cfg_data[30:0];
                CFG_SCAN_INC:   scan_inc_reg    <= cfg_data;
                CFG_FRAME_POS:  frame_pos_reg   <= cfg_data[23:0];
                CFG_GAIN_LEFT:  gain_reg[0]     <= cfg_data[15:0];
                CFG_GAIN_RIGHT: gain_reg[1]     <= cfg_data[15:0];
                CFG_PHASE_MODE: phase_mode_reg  <= cfg_data[1:0];
                CFG_SCAN_MODE:  scan_mode_reg   <= cfg_data[0];
                CFG_FIXED_PH:   fixed_phase_reg <= cfg_data;
                default:        phase_mode_reg  <= phase_mode_reg;
            endcase
        end
    end

    // Phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            osc_phase_reg  <= '0;
            scan_phase_reg <= '0;
        end
        else
        begin
            if (cmd.trig)
            begin
                case (phase_mode_reg)
                    PM_FIXED:  osc_phase_reg <= fixed_phase_reg;
                    PM_RANDOM: osc_phase_reg <= random_phase;
                    default:   osc_phase_reg <= '0;
                endcase
            end
            else if (cmd.acc_add)
            begin
                osc_phase_reg <= osc_phase_reg + {1'b0, phase_inc_reg};
            end
            if (cmd.scan_step && scan_mode_reg)
            begin
                scan_phase_reg <= scan_phase_reg + scan_inc_reg;
            end
        end
    end

    // Frame selection
    logic [32+NF_W-1:0] scan_prod;
    logic [IW-1:0]      fint_reg;
    logic [15:0]        ffrac_reg;
    logic [NF_W-1:0]    fa_reg;
    logic [NF_W-1:0]    fb_reg;
    logic [NF_W-1:0]    fa_next;
    logic [AW-1:0]      base_reg [2];

    assign scan_prod = scan_phase_reg * NF_M1;

    // Integer part modulo the frame count, one bit per restoring step.
    always_comb
    begin
        logic [NF_W:0] r;
        r = '0;
        for (int i = IW - 1; i >= 0; i--)
        begin
            r = {r[NF_W-1:0], fint_reg[i]};
            if (r >= NF_C)
            begin
                r = r - NF_C;
            end
        end
        fa_next = r[NF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.frame_load)
        begin
            if (scan_mode_reg)
            begin
                fint_reg  <= IW'(scan_prod[32 +: NF_W]);
                ffrac_reg <= scan_prod[31:16];
            end
            else
            begin
                fint_reg  <= IW'(frame_pos_reg[23:16]);
                ffrac_reg <= frame_pos_reg[15:0];
            end
        end
        if (cmd.frame_wrap)
        begin
            fa_reg <= fa_next;
            fb_reg <= (fa_next == NF_M1) ? '0 : fa_next + NF_W'(1);
        end
        if (cmd.base_load)
        begin
            base_reg[0] <= AW'(fa_reg) * FL_AW;
            base_reg[1] <= AW'(fb_reg) * FL_AW;
        end
    end

    // Sample position within the frame
    logic [32+FL_W:0] pos_prod;
    logic [FL_W-1:0]  sa_reg;
    logic [FL_W-1:0]  sb_reg;
    logic [15:0]      fs_reg;
    logic [FL_W-1:0]  sa_next;

    assign pos_prod = osc_phase_reg * FL_C;
    assign sa_next  = pos_prod[32 +: FL_W];

    always_ff @(posedge clk)
    begin
        if (cmd.pos_load)
        begin
            sa_reg <= sa_next;
            sb_reg <= (sa_next == FL_M1) ? '0 : sa_next + FL_W'(1);
            fs_reg <= pos_prod[31:16];
        end
    end

    // Table
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       ram_addr;
    logic                wr_ok;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign rd_addr  = base_reg[cmd.rd_sel[1]] + AW'(cmd.rd_sel[0] ? sb_reg : sa_reg);
    assign wr_ok    = CW'(table_address) < DEPTH_C;
    assign ram_addr = cmd.tbl_write ? AW'(table_address) : rd_addr;

    wtosc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.tbl_write && wr_ok),
        .addr  (ram_addr),
        .wdata (table_value),
        .rdata (ram_rdata)
    );

    // Bilinear interpolation; samples are A/B of frame A, then A/B of frame B.
    logic signed [SAMPLE_W-1:0] smp_reg [4];
    logic signed [ROW_W-1:0]    row_reg [2];
    logic signed [ROW_W-1:0]    row_next [2];
    logic signed [16:0]         fs17;
    logic signed [16:0]         ff17;
    logic signed [ROW_W:0]      drow;
    logic signed [COL_W-1:0]    col_reg;
    logic signed [PV_W-1:0]     pv_full;
    logic signed [PV_W-25:0]    pv;
    logic signed [SUM_W-1:0]    sum_reg;

    assign fs17 = $signed({1'b0, fs_reg});
    assign ff17 = $signed({1'b0, ffrac_reg});

    always_comb
    begin
        logic signed [SAMPLE_W:0] diff;
        for (int j = 0; j < 2; j++)
        begin
            diff = (SAMPLE_W + 1)'(smp_reg[2*j+1]) - (SAMPLE_W + 1)'(smp_reg[2*j]);
            row_next[j] = (ROW_W'(smp_reg[2*j]) <<< 16) + ROW_W'(fs17) * ROW_W'(diff);
        end
    end

    assign drow    = (ROW_W + 1)'(row_reg[1]) - (ROW_W + 1)'(row_reg[0]);
    assign pv_full = (PV_W'(row_reg[0]) <<< 16) + PV_W'(col_reg);
    assign pv      = pv_full[PV_W-1:24];

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            smp_reg[cmd.cap_sel] <= ram_rdata;
        end
        if (cmd.row_load)
        begin
            row_reg[0] <= row_next[0];
            row_reg[1] <= row_next[1];
        end
        if (cmd.col_load)
        begin
            col_reg <= COL_W'(ff17) * COL_W'(drow);
        end
        if (cmd.acc_clr)
        begin
            sum_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            sum_reg <= sum_reg + SUM_W'(pv);
        end
    end

    // Gain, floor divide by the oversample factor, saturation; lane 0 is left.
    logic signed [GP_W-1:0] gprod_reg [2];
    logic [DIV_W-1:0]       dvd_reg [2];
    logic [DIV_W-1:0]       quo_reg [2];
    logic                   neg_reg [2];
    logic [DIV_W-1:0]       mag [2];
    logic [MP_W-1:0]        qprod [2];
    logic signed [Q_W-1:0]  sat [2];

    always_comb
    begin
        logic signed [T_W-1:0]   t;
        logic signed [Q_W-1:0]   q;
        for (int k = 0; k < 2; k++)
        begin
            t  = gprod_reg[k][GP_W-1:22];
            // Negative values divide as ceiling of the magnitude.
            mag[k] = t[T_W-1] ? DIV_W'(-t) + OS_M1 : DIV_W'(t);
            qprod[k] = MP_W'(dvd_reg[k]) * MP_W'(RECIP);
            q = $signed(Q_W'(quo_reg[k]));
            if (neg_reg[k])
            begin
                q = -q;
            end
            if (q > SAT_HI)
            begin
                sat[k] = SAT_HI;
            end
            else if (q < SAT_LO)
            begin
                sat[k] = SAT_LO;
            end
            else
            begin
                sat[k] = q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 2; k++)
        begin
            if (cmd.gain_load)
            begin
                gprod_reg[k] <= GP_W'(sum_reg) * $signed(GP_W'({1'b0, gain_reg[k]}));
            end
            if (cmd.div_init)
            begin
                dvd_reg[k] <= mag[k];
                neg_reg[k] <= gprod_reg[k][GP_W-1];
            end
            if (cmd.div_step)
            begin
                quo_reg[k] <= DIV_W'(qprod[k] >> RSH);
            end
        end
    end

    // Output register
    logic                       m_tvalid_reg;
    logic signed [SAMPLE_W-1:0] left_reg;
    logic signed [SAMPLE_W-1:0] right_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            left_reg  <= sat[0][SAMPLE_W-1:0];
            right_reg <= sat[1][SAMPLE_W-1:0];
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign left_sample     = left_reg;
    assign right_sample    = right_reg;
    assign status.out_busy = m_tvalid_reg && !m_tready;

endmodule

// ----- hw/rtl/wavetable_oscillator_bilinear.sv -----
// ----------------------------------------------------------------------------
// Wavetable oscillator with bilinear interpolation
// Stereo oscillator over a table of frames, with oversampling, gain and pan.
//
//   channel | direction | transaction carries
//   s_*     | in        | tuser: opcode; tdata: address, value, random phase
//   m_*     | out       | tdata: left sample, right sample
//   cfg_*   | in        | register index and data, one write per cycle
//
// A table write or a trigger is done in the idle state. A tick makes four
// single-port table reads per pass, one pass per oversample, then a
// reciprocal multiply for the divide.
// Reset clears the phases and restores the register defaults; the table
// holds no reset value.
// A result waiting on m_tready holds the sequencer only in its last step.
// ----------------------------------------------------------------------------
module wavetable_oscillator_bilinear #(
    parameter int NUM_FRAMES_P      = 256,
    parameter int FRAME_LENGTH      = 2048,
    parameter int OVERSAMPLE_FACTOR = 4,
    parameter int SAMPLE_BITS       = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [1:0]                           s_tuser,   // opcode
    input  logic [79:0]                          s_tdata,   // table_address,
                                                            // table_value,
                                                            // random_phase
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [47:0]                          m_tdata,   // left_sample,
                                                            // right_sample
    input  logic                                 cfg_we,
    input  logic [wtosc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wtosc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import wtosc_pkg::*;

    localparam int SUM_W = 33 + $clog2(OVERSAMPLE_FACTOR);

    wtosc_cmd_t                 cmd;
    wtosc_status_t              status;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;

    wtosc_ctrl #(
        .OVERSAMPLE_FACTOR (OVERSAMPLE_FACTOR)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    wtosc_dp #(
        .NUM_FRAMES_P      (NUM_FRAMES_P),
        .FRAME_LENGTH      (FRAME_LENGTH),
        .OVERSAMPLE_FACTOR (OVERSAMPLE_FACTOR),
        .SAMPLE_BITS       (SAMPLE_BITS),
        .SUM_W             (SUM_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .table_address (s_tdata[18:0]),
        .table_value   (s_tdata[42:19]),
        .random_phase  (s_tdata[74:43]),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .left_sample   (left_sample),
        .right_sample  (right_sample)
    );

    assign m_tdata = {right_sample, left_sample};

endmodule

// ----- verif/tb_wavetable_oscillator_bilinear.sv -----
// ----------------------------------------------------------------------------
// Testbench for the bilinear wavetable oscillator
// Streams table writes, triggers and ticks into the oscillator and checks each
// stereo sample against a cycle-free model of the oscillator. Table entries
// are written before any tick can read them. Both stream sides stall at
// random, and one long output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_wavetable_oscillator_bilinear;

    import wtosc_pkg::*;

    localparam int FRAME_COUNT  = 256;
    localparam int FRAME_LEN    = 2048;
    localparam int TICK_CYCLES  = 45;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [1:0] PM_RESERVED = 2'd3;

    typedef struct {
        logic [23:0] left_sample;
        logic [23:0] right_sample;
    } stereo_t;

    class osc_scoreboard;
        bit [31:0] phase_inc, scan_inc, fixed_ph;
        bit [23:0] frame_pos;
        bit [15:0] gain_l, gain_r;
        bit [1:0]  pmode;
        bit        scan_on;
        bit [31:0] osc_ph, scan_ph;
        bit [23:0] wave[int];
        stereo_t   due[$];
        int        errors;

        function new();
            phase_inc = 0; scan_inc = 0; fixed_ph = 0; frame_pos = 0;
            gain_l = 16384; gain_r = 16384; pmode = PM_ZERO; scan_on = 0;
            osc_ph = 0; scan_ph = 0; errors = 0;
        endfunction

        function void set_reg(wtosc_cfg_idx_t idx, bit [31:0] v);
            case (idx)
                CFG_PHASE_INC:  phase_inc = {1'b0, v[30:0]};
                CFG_SCAN_INC:   scan_inc = v;
                CFG_FRAME_POS:  frame_pos = v[23:0];
                CFG_GAIN_LEFT:  gain_l = v[15:0];
                CFG_GAIN_RIGHT: gain_r = v[15:0];
                CFG_PHASE_MODE: pmode = v[1:0];
                CFG_SCAN_MODE:  scan_on = v[0];
                default:        fixed_ph = v;
            endcase
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Frame pair and frame fraction for a tick that sees scan phase sp.
        function void frames(bit [31:0] sp, output int fa, output int fb,
                             output longint ff);
            longint fpos;
            fpos = scan_on ? ((longint'(sp) * (FRAME_COUNT - 1)) >> 16)
                           : longint'(frame_pos);
            fa = int'((fpos >> 16) % FRAME_COUNT);
            fb = (fa + 1) % FRAME_COUNT;
            ff = fpos & 16'hFFFF;
        endfunction

        // Table addresses the next tick reads that have never been written.
        function void unwritten(ref int addrs[$]);
            int fa, fb, sa, sb;
            longint ff;
            bit [31:0] ph;
            int cand[4];
            addrs.delete();
            frames(scan_ph + scan_inc, fa, fb, ff);
            ph = osc_ph;
            for (int k = 0; k < 4; k++)
            begin
                sa = int'(((longint'(ph) << 11) >> 32) & (FRAME_LEN - 1));
                sb = (sa + 1) % FRAME_LEN;
                cand = '{fa * FRAME_LEN + sa, fa * FRAME_LEN + sb,
                         fb * FRAME_LEN + sa, fb * FRAME_LEN + sb};
                foreach (cand[i])
                    if (!wave.exists(cand[i]) && !(cand[i] inside {addrs}))
                        addrs.push_back(cand[i]);
                ph += phase_inc;
            end
        endfunction

        function longint smp(int fr, int sa);
            return longint'($signed(wave[fr * FRAME_LEN + sa]));
        endfunction

        function logic [23:0] scaled(longint sum, bit [15:0] g);
            longint v;
            v = (sum * longint'(g)) >>> 24;
            if (v > 64'sd8388607) v = 8388607;
            if (v < -64'sd8388608) v = -8388608;
            return v[23:0];
        endfunction

        function void note_input(logic [1:0] op, logic [18:0] addr,
                                 logic [23:0] val, logic [31:0] rph);
            int fa, fb, sa, sb;
            longint ff, fs, ra, rb, sum, p;
            stereo_t r;
            if (op == OP_WRITE)
                wave[int'(addr)] = val;
            else if (op == OP_TRIG)
                osc_ph = (pmode == PM_FIXED) ? fixed_ph :
                         (pmode == PM_RANDOM) ? rph : 32'd0;
            else if (op == OP_TICK)
            begin
                if (scan_on)
                    scan_ph += scan_inc;
                frames(scan_ph, fa, fb, ff);
                sum = 0;
                for (int k = 0; k < 4; k++)
                begin
                    p  = longint'(osc_ph) << 11;
                    sa = int'((p >> 32) & (FRAME_LEN - 1));
                    sb = (sa + 1) % FRAME_LEN;
                    fs = (p >> 16) & 16'hFFFF;
                    ra = smp(fa, sa) * 65536 + fs * (smp(fa, sb) - smp(fa, sa));
                    rb = smp(fb, sa) * 65536 + fs * (smp(fb, sb) - smp(fb, sa));
                    sum += (ra * 65536 + ff * (rb - ra)) >>> 24;
                    osc_ph += phase_inc;
                end
                r.left_sample  = scaled(sum, gain_l);
                r.right_sample = scaled(sum, gain_r);
                due.push_back(r);
            end
        endfunction

        function void check_result(logic [23:0] l, logic [23:0] r);
            stereo_t e;
            if (due.size() == 0)
            begin
                $error("output transaction with no sample expected: %h %h", l, r);
                errors++;
                return;
            end
            e = due.pop_front();
            if (l !== e.left_sample)
            begin
                $error("left_sample: expected %h, actual %h", e.left_sample, l);
                errors++;
            end
            if (r !== e.right_sample)
            begin
                $error("right_sample: expected %h, actual %h", e.right_sample, r);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;   // opcode
    logic [79:0] s_tdata;   // table_address, table_value, random_phase, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // left_sample, right_sample
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    osc_scoreboard sb;
    int  cycles;
    bit  no_idle;
    bit  hold_req;
    int  gap_pct;

    wavetable_oscillator_bilinear i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[23:0], m_tdata[47:24]);
    end

    // Output side: random stalls, one long hold on request, none at the end.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (no_idle)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_req = 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    task automatic send(logic [1:0] op, logic [18:0] addr, logic [23:0] val,
                        logic [31:0] rph);
        s_tuser  <= op;
        s_tdata  <= {5'b0, rph, val, addr};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_input(op, addr, val, rph);
        if (!no_idle && $urandom_range(1, 100) <= gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h800000;
            1:       return 24'h7FFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    // A tick goes out only once every table entry it reads holds a value.
    task automatic tick();
        int addrs[$];
        sb.unwritten(addrs);
        foreach (addrs[i])
            send(OP_WRITE, 19'(addrs[i]), rand_sample(), $urandom);
        send(OP_TICK, 19'($urandom), 24'($urandom), $urandom);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TICK_CYCLES + 20) @(posedge clk);
    endtask

    task automatic load_regs(bit [31:0] v[8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= v[i];
            @(posedge clk);
            sb.set_reg(wtosc_cfg_idx_t'(i), v[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic bit [31:0] pick(bit [31:0] lo, bit [31:0] hi, bit [31:0] r);
        case ($urandom_range(0, 5))
            0:       return lo;
            1:       return hi;
            default: return r;
        endcase
    endfunction

    task automatic random_phase(int n);
        bit [31:0] v[8];
        int sel;
        v[CFG_PHASE_INC]  = pick(0, 32'h7FFFFFFF, $urandom_range(0, 3) == 0 ?
                                 $urandom : $urandom_range(0, 32'h00FFFFFF));
        v[CFG_SCAN_INC]   = pick(0, 32'hFFFFFFFF, $urandom);
        v[CFG_FRAME_POS]  = pick(0, 32'h00FF0000, $urandom_range(0, 32'hFFFFFF));
        v[CFG_GAIN_LEFT]  = pick(0, 32'hFFFF, $urandom_range(0, 32'hFFFF));
        v[CFG_GAIN_RIGHT] = pick(0, 32'hFFFF, $urandom_range(0, 32'hFFFF));
        v[CFG_PHASE_MODE] = $urandom_range(PM_ZERO, PM_RESERVED);
        v[CFG_SCAN_MODE]  = $urandom_range(0, 1);
        v[CFG_FIXED_PH]   = pick(0, 32'hFFFFFFFF, $urandom);
        load_regs(v);
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50)
                tick();
            else if (sel < 65)
                send(OP_TRIG, 19'($urandom), 24'($urandom), $urandom);
            else if (sel < 95)
                send(OP_WRITE, 19'($urandom), rand_sample(), $urandom);
            else
                send(OP_RESERVED, 19'($urandom), 24'($urandom), $urandom);
        end
        drain();
    endtask

    initial
    begin
        bit [31:0] v[8];
        sb        = new();
        cycles    = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        gap_pct   = 25;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = OP_TICK;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme samples at the table ends, the fixed, random and reserved
        // trigger modes, the reserved opcode, and a frame position in the last frame.
        send(OP_WRITE, 19'h00000, 24'h7FFFFF, 32'h0);
        send(OP_WRITE, 19'h00001, 24'h800000, 32'h0);
        send(OP_WRITE, 19'h7FFFF, 24'h800000, 32'hFFFFFFFF);
        tick();
        tick();
        send(OP_RESERVED, 19'h7FFFF, 24'hFFFFFF, 32'hFFFFFFFF);
        drain();
        v = '{32'h7FFFFFFF, 32'hFFFFFFFF, 32'h00FFFFFF, 32'hFFFF, 32'hFFFF,
              PM_FIXED, 32'd1, 32'hFFFFFFFF};
        load_regs(v);
        send(OP_TRIG, 19'h0, 24'h0, 32'h0);
        tick();
        tick();
        drain();
        v = '{32'd0, 32'd0, 32'h00FF8000, 32'd0, 32'hFFFF, PM_RANDOM, 32'd0,
              32'd0};
        load_regs(v);
        send(OP_TRIG, 19'h0, 24'h0, 32'hFFFFFFFF);
        tick();
        send(OP_TRIG, 19'h0, 24'h0, 32'h80000000);
        tick();
        drain();
        v = '{32'h00100000, 32'h01000000, 32'h00010000, 32'h4000, 32'h0,
              PM_RESERVED, 32'd0, 32'h12345678};
        load_regs(v);
        send(OP_TRIG, 19'h0, 24'h0, 32'hFFFFFFFF);
        tick();
        tick();
        drain();

        // Random phases; the second one includes a long output stall.
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 1)
                hold_req = 1'b1;
            random_phase(36);
        end
        no_idle = 1'b1;
        random_phase(36);

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TICK_CYCLES + 20) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
